// File: design/escatr_pkg.sv
package escatr_pkg;

  // Field widths fixed by the item format
  localparam int unsigned LEVEL_W   = 14;
  localparam int unsigned TOL_W     = 14;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned TIME_IN_W = 16;

  localparam int unsigned TIME_WIDTH_DEF = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 14'd10000;
  localparam logic [TOL_W-1:0]   TOL_RESET = 14'd100;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_BEGIN    = 3'd1;
  localparam logic [OP_W-1:0] OP_ARM      = 3'd2;
  localparam logic [OP_W-1:0] OP_DISARM   = 3'd3;
  localparam logic [OP_W-1:0] OP_SET      = 3'd4;
  localparam logic [OP_W-1:0] OP_STOP     = 3'd5;
  localparam logic [OP_W-1:0] OP_STOP_ERR = 3'd6;

  // Sequencer modes
  localparam logic [MODE_W-1:0] MODE_DISARMED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ARMING   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ARMED    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RUNNING  = 2'd3;

  // Actuator status
  localparam logic [STAT_W-1:0] STAT_INIT    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_STOPPED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ACTIVE  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ERROR   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic cap;   // capture the accepted item
    logic exec;  // apply the operation to the sequencer state
    logic mul;   // form |target-start| * elapsed, seed the divider
    logic step;  // one restoring division step
    logic fin;   // write the interpolated level
    logic resp;  // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_interp;
  } stat_t;

endpackage

// File: design/escatr_dp.sv
module escatr_dp #(
  parameter int unsigned TIME_WIDTH = escatr_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  escatr_pkg::cmd_t                  cmd_i,
  output escatr_pkg::stat_t                 stat_o,
  input  logic                              cfg_we_i,
  input  logic [escatr_pkg::TOL_W-1:0]      cfg_wdata_i,
  input  logic [escatr_pkg::OP_W-1:0]       op_i,
  input  logic [escatr_pkg::TIME_IN_W-1:0]  arm_time_ms_i,
  input  logic [escatr_pkg::LEVEL_W-1:0]    throttle_req_i,
  input  logic                              smooth_i,
  input  logic [escatr_pkg::TIME_IN_W-1:0]  ramp_time_ms_i,
  output logic                              ok_o,
  output logic [escatr_pkg::LEVEL_W-1:0]    throttle_out_o,
  output logic                              drive_write_o,
  output logic                              drive_stop_o,
  output logic [escatr_pkg::MODE_W-1:0]     esc_mode_o,
  output logic [escatr_pkg::STAT_W-1:0]     act_status_o,
  output logic                              ramping_o,
  output logic                              at_target_o,
  output logic [escatr_pkg::LEVEL_W-1:0]    applied_throttle_o
);

  localparam int unsigned LW = escatr_pkg::LEVEL_W;
  localparam int unsigned EW = TIME_WIDTH + 1;
  localparam int unsigned PW = LW + TIME_WIDTH;
  localparam logic [EW-1:0] ELAPSED_MAX = {EW{1'b1}};

  // Captured item
  logic [escatr_pkg::OP_W-1:0] op_q;
  logic [TIME_WIDTH-1:0]       arm_q;
  logic [LW-1:0]               req_q;
  logic                        smooth_q;
  logic [TIME_WIDTH-1:0]       rlen_in_q;

  // Sequencer state
  logic [escatr_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [escatr_pkg::STAT_W-1:0] status_q, status_d;
  logic [LW-1:0]                 cur_q, cur_d;
  logic [LW-1:0]                 tgt_q, tgt_d;
  logic [LW-1:0]                 start_q, start_d;
  logic                          ramp_q, ramp_d;
  logic [EW-1:0]                 elapsed_q, elapsed_d;
  logic [TIME_WIDTH-1:0]         hold_q, hold_d;
  logic [TIME_WIDTH-1:0]         len_q, len_d;
  logic [escatr_pkg::TOL_W-1:0]  tol_q;

  // Per-item flags
  logic          ok_q, ok_d;
  logic          dw_q, dw_d;
  logic          ds_q, ds_d;
  logic [LW-1:0] applied_q, applied_d;
  logic          need_interp;

  // Interpolation datapath
  logic [LW-1:0]         mag_q;
  logic                  neg_q;
  logic [PW-1:0]         prod;
  logic [TIME_WIDTH-1:0] rem_q;
  logic [LW-1:0]         quo_q;
  logic [TIME_WIDTH:0]   trial;
  logic [TIME_WIDTH:0]   trial_sub;
  logic                  trial_ge;
  logic [LW:0]           interp;

  logic [EW-1:0] elapsed_inc;
  logic          ready;
  logic [LW-1:0] gap;

  assign ready = (status_q == escatr_pkg::STAT_STOPPED) ||
                 (status_q == escatr_pkg::STAT_ACTIVE);
  assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + EW'(1);

  assign stat_o.need_interp = need_interp;

  // Item capture, request saturated on the way in
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q      <= op_i;
      arm_q     <= TIME_WIDTH'(arm_time_ms_i);
      req_q     <= (throttle_req_i > escatr_pkg::LEVEL_MAX) ? escatr_pkg::LEVEL_MAX
                                                            : throttle_req_i;
      smooth_q  <= smooth_i;
      rlen_in_q <= TIME_WIDTH'(ramp_time_ms_i);
    end
  end

  // Operation decode
  always_comb begin
    mode_d      = mode_q;
    status_d    = status_q;
    cur_d       = cur_q;
    tgt_d       = tgt_q;
    start_d     = start_q;
    ramp_d      = ramp_q;
    elapsed_d   = elapsed_q;
    hold_d      = hold_q;
    len_d       = len_q;
    ok_d        = 1'b0;
    dw_d        = 1'b0;
    ds_d        = 1'b0;
    applied_d   = '0;
    need_interp = 1'b0;

    unique case (op_q)
      escatr_pkg::OP_TICK: begin
        elapsed_d = elapsed_inc;
        if (ready) begin
          if (mode_q == escatr_pkg::MODE_ARMING) begin
            if (elapsed_inc >= {1'b0, hold_q}) begin
              mode_d = escatr_pkg::MODE_ARMED;
            end
            ok_d = 1'b1;
          end else if (ramp_q && (mode_q != escatr_pkg::MODE_DISARMED)) begin
            ok_d = 1'b1;
            dw_d = 1'b1;
            if (elapsed_inc >= {1'b0, len_q}) begin
              ramp_d = 1'b0;
              cur_d  = tgt_q;
              if (tgt_q == '0) begin
                mode_d   = escatr_pkg::MODE_ARMED;
                status_d = escatr_pkg::STAT_STOPPED;
              end else begin
                mode_d   = escatr_pkg::MODE_RUNNING;
                status_d = escatr_pkg::STAT_ACTIVE;
              end
            end else begin
              need_interp = 1'b1;
            end
          end
        end
      end
      escatr_pkg::OP_BEGIN, escatr_pkg::OP_STOP, escatr_pkg::OP_STOP_ERR: begin
        ds_d     = 1'b1;
        cur_d    = '0;
        tgt_d    = '0;
        ramp_d   = 1'b0;
        mode_d   = escatr_pkg::MODE_DISARMED;
        status_d = (op_q == escatr_pkg::OP_STOP_ERR) ? escatr_pkg::STAT_ERROR
                                                     : escatr_pkg::STAT_STOPPED;
        ok_d     = 1'b1;
      end
      escatr_pkg::OP_ARM: begin
        if (ready && (mode_q == escatr_pkg::MODE_DISARMED)) begin
          ds_d      = 1'b1;
          elapsed_d = '0;
          hold_d    = arm_q;
          mode_d    = escatr_pkg::MODE_ARMING;
          ok_d      = 1'b1;
        end
      end
      escatr_pkg::OP_DISARM: begin
        if (ready && (mode_q == escatr_pkg::MODE_ARMED)) begin
          ds_d   = 1'b1;
          cur_d  = '0;
          tgt_d  = '0;
          ramp_d = 1'b0;
          mode_d = escatr_pkg::MODE_DISARMED;
          ok_d   = 1'b1;
        end
      end
      escatr_pkg::OP_SET: begin
        if (ready && ((mode_q == escatr_pkg::MODE_ARMED) ||
                      (mode_q == escatr_pkg::MODE_RUNNING))) begin
          tgt_d = req_q;
          if (smooth_q) begin
            start_d   = cur_q;
            len_d     = rlen_in_q;
            elapsed_d = '0;
            ramp_d    = 1'b1;
            if (req_q != '0) begin
              mode_d = escatr_pkg::MODE_RUNNING;
            end
            status_d  = escatr_pkg::STAT_ACTIVE;
          end else begin
            cur_d    = req_q;
            dw_d     = 1'b1;
            mode_d   = (req_q != '0) ? escatr_pkg::MODE_RUNNING : escatr_pkg::MODE_ARMED;
            status_d = (req_q != '0) ? escatr_pkg::STAT_ACTIVE : escatr_pkg::STAT_STOPPED;
          end
          applied_d = req_q;
          ok_d      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Interpolation: product, restoring divide, signed add-back
  assign prod      = PW'(mag_q) * PW'(elapsed_q[TIME_WIDTH-1:0]);
  assign trial     = {rem_q, quo_q[LW-1]};
  assign trial_ge  = trial >= {1'b0, len_q};
  assign trial_sub = trial - {1'b0, len_q};
  assign interp    = neg_q ? ({1'b0, start_q} - {1'b0, quo_q})
                           : ({1'b0, start_q} + {1'b0, quo_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      neg_q <= tgt_q < start_q;
      mag_q <= (tgt_q < start_q) ? (start_q - tgt_q) : (tgt_q - start_q);
    end
    if (cmd_i.mul) begin
      rem_q <= prod[PW-1:LW];
      quo_q <= prod[LW-1:0];
    end else if (cmd_i.step) begin
      rem_q <= trial_ge ? trial_sub[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
      quo_q <= {quo_q[LW-2:0], trial_ge};
    end
    if (cmd_i.exec) begin
      ok_q      <= ok_d;
      dw_q      <= dw_d;
      ds_q      <= ds_d;
      applied_q <= applied_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= escatr_pkg::MODE_DISARMED;
      status_q  <= escatr_pkg::STAT_INIT;
      cur_q     <= '0;
      tgt_q     <= '0;
      start_q   <= '0;
      ramp_q    <= 1'b0;
      elapsed_q <= '0;
      hold_q    <= '0;
      len_q     <= '0;
      tol_q     <= escatr_pkg::TOL_RESET;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        mode_q    <= mode_d;
        status_q  <= status_d;
        cur_q     <= cur_d;
        tgt_q     <= tgt_d;
        start_q   <= start_d;
        ramp_q    <= ramp_d;
        elapsed_q <= elapsed_d;
        hold_q    <= hold_d;
        len_q     <= len_d;
      end else if (cmd_i.fin) begin
        cur_q <= interp[LW-1:0];
      end
    end
  end

  // Result register
  assign gap = (cur_q >= tgt_q) ? (cur_q - tgt_q) : (tgt_q - cur_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      ok_o               <= ok_q;
      throttle_out_o     <= cur_q;
      drive_write_o      <= dw_q;
      drive_stop_o       <= ds_q;
      esc_mode_o         <= mode_q;
      act_status_o       <= status_q;
      ramping_o          <= ramp_q;
      at_target_o        <= gap <= tol_q;
      applied_throttle_o <= applied_q;
    end
  end

endmodule

// File: design/escatr_ctrl.sv
module escatr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output escatr_pkg::cmd_t   cmd_o,
  input  escatr_pkg::stat_t  stat_i
);

  localparam int unsigned STEPS = escatr_pkg::LEVEL_W;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_RESP = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.need_interp ? ST_MUL : ST_RESP;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + CNT_W'(1);
        if (cnt_q == LAST_STEP) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        // hold until the result register is free
        if (slot_free) begin
          cmd_o.resp  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/esc_arming_throttle_ramp.sv
// Sequencing: each item is captured on transfer and applied; a tick that
//   interpolates the throttle ramp then runs the multiply, the 14-step
//   restoring divider and the add-back before the result register loads.
// Throughput: one item at a time; a new item is taken only after the last
//   one's result is loaded, which waits while the result register is held.
// Reset (rst_ni low, asynchronous): disarmed, initializing, all levels and
//   timers zero, no ramp, tolerance 100, no result pending.
module esc_arming_throttle_ramp #(
  parameter int unsigned TIME_WIDTH = escatr_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tolerance register write port
  input  logic                              cfg_we_i,
  input  logic [escatr_pkg::TOL_W-1:0]      cfg_wdata_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [escatr_pkg::OP_W-1:0]       op_i,
  input  logic [escatr_pkg::TIME_IN_W-1:0]  arm_time_ms_i,
  input  logic [escatr_pkg::LEVEL_W-1:0]    throttle_req_i,
  input  logic                              smooth_i,
  input  logic [escatr_pkg::TIME_IN_W-1:0]  ramp_time_ms_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic [escatr_pkg::LEVEL_W-1:0]    throttle_out_o,
  output logic                              drive_write_o,
  output logic                              drive_stop_o,
  output logic [escatr_pkg::MODE_W-1:0]     esc_mode_o,
  output logic [escatr_pkg::STAT_W-1:0]     act_status_o,
  output logic                              ramping_o,
  output logic                              at_target_o,
  output logic [escatr_pkg::LEVEL_W-1:0]    applied_throttle_o
);

  // The controller sequences each item: capture on transfer, apply the
  // operation, and only for a mid-ramp tick run the multiply / divide /
  // add-back chain before loading the result register.
  escatr_pkg::cmd_t  cmd;
  escatr_pkg::stat_t stat;

  escatr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // The datapath owns the sequencer state, the ramp arithmetic
  // (one multiplier, one restoring divider) and the result register.
  escatr_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .op_i               (op_i),
    .arm_time_ms_i      (arm_time_ms_i),
    .throttle_req_i     (throttle_req_i),
    .smooth_i           (smooth_i),
    .ramp_time_ms_i     (ramp_time_ms_i),
    .ok_o               (ok_o),
    .throttle_out_o     (throttle_out_o),
    .drive_write_o      (drive_write_o),
    .drive_stop_o       (drive_stop_o),
    .esc_mode_o         (esc_mode_o),
    .act_status_o       (act_status_o),
    .ramping_o          (ramping_o),
    .at_target_o        (at_target_o),
    .applied_throttle_o (applied_throttle_o)
  );

`ifndef SYNTHESIS
  // An accepted transfer always makes the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input stall not raised after transfer");

  // Begin, stop and disarm enter disarmed, and each clears throttle and ramp.
  a_disarmed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (esc_mode_o == escatr_pkg::MODE_DISARMED))
      |-> ((throttle_out_o == '0) && !ramping_o))
    else $error("disarmed with throttle or ramp held");

  // A stop pulse and a throttle write never come from the same item.
  a_write_xor_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(drive_write_o && drive_stop_o))
    else $error("drive write and stop in one result");
`endif

endmodule

// File: dv/esc_ramp_checker.sv
module esc_ramp_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [escatr_pkg::TOL_W-1:0]     cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [escatr_pkg::OP_W-1:0]      op_i,
  input  logic [escatr_pkg::TIME_IN_W-1:0] arm_time_ms_i,
  input  logic [escatr_pkg::LEVEL_W-1:0]   throttle_req_i,
  input  logic                             smooth_i,
  input  logic [escatr_pkg::TIME_IN_W-1:0] ramp_time_ms_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic                             ok_i,
  input  logic [escatr_pkg::LEVEL_W-1:0]   throttle_out_i,
  input  logic                             drive_write_i,
  input  logic                             drive_stop_i,
  input  logic [escatr_pkg::MODE_W-1:0]    esc_mode_i,
  input  logic [escatr_pkg::STAT_W-1:0]    act_status_i,
  input  logic                             ramping_i,
  input  logic                             at_target_i,
  input  logic [escatr_pkg::LEVEL_W-1:0]   applied_throttle_i,
  output int unsigned                      mismatches_o,
  output int unsigned                      pending_o
);
  import escatr_pkg::*;

  // elapsed counter is one bit wider than the time fields and saturates
  localparam int unsigned   MS_W    = TIME_WIDTH_DEF + 1;
  localparam logic [MS_W-1:0] MS_CEIL = '1;

  typedef struct packed {
    logic               ok;
    logic [LEVEL_W-1:0] throttle;
    logic               drive_write;
    logic               drive_stop;
    logic [MODE_W-1:0]  mode;
    logic [STAT_W-1:0]  status;
    logic               ramping;
    logic               at_target;
    logic [LEVEL_W-1:0] applied;
  } esc_result_t;

  esc_result_t expected_results[$];
  int unsigned mismatch_cnt = 0;

  logic [TOL_W-1:0]     tol;
  logic [MODE_W-1:0]    seq_mode;
  logic [STAT_W-1:0]    act_stat;
  logic [LEVEL_W-1:0]   level_now;
  logic [LEVEL_W-1:0]   level_goal;
  logic [LEVEL_W-1:0]   level_from;
  logic                 ramp_on;
  logic [MS_W-1:0]      ms_count;
  logic [TIME_IN_W-1:0] arm_hold;
  logic [TIME_IN_W-1:0] ramp_span;

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Apply one item to the sequencer copy and form the result it causes.
  task automatic advance_sequencer(
    input  logic [OP_W-1:0]      op,
    input  logic [TIME_IN_W-1:0] arm_ms,
    input  logic [LEVEL_W-1:0]   req_raw,
    input  logic                 smooth,
    input  logic [TIME_IN_W-1:0] ramp_ms,
    output esc_result_t          res
  );
    logic [LEVEL_W-1:0] req;
    logic [LEVEL_W-1:0] gap;
    logic               ready;
    longint             delta;
    res   = '0;
    req   = (req_raw > LEVEL_MAX) ? LEVEL_MAX : req_raw;
    ready = (act_stat == STAT_STOPPED) || (act_stat == STAT_ACTIVE);
    case (op)
      OP_TICK: begin
        if (ms_count != MS_CEIL) ms_count = ms_count + 1'b1;
        if (ready && seq_mode == MODE_ARMING) begin
          if (ms_count >= arm_hold) seq_mode = MODE_ARMED;
          res.ok = 1'b1;
        end else if (ready && ramp_on && seq_mode != MODE_DISARMED) begin
          res.ok          = 1'b1;
          res.drive_write = 1'b1;
          if (ms_count >= ramp_span) begin
            ramp_on   = 1'b0;
            level_now = level_goal;
            seq_mode  = (level_goal == '0) ? MODE_ARMED : MODE_RUNNING;
            act_stat  = (level_goal == '0) ? STAT_STOPPED : STAT_ACTIVE;
          end else begin
            // signed division truncates toward zero
            delta     = longint'(level_goal) - longint'(level_from);
            level_now = LEVEL_W'(longint'(level_from)
                                 + delta * longint'(ms_count) / longint'(ramp_span));
          end
        end
      end
      OP_BEGIN, OP_STOP, OP_STOP_ERR: begin
        res.ok         = 1'b1;
        res.drive_stop = 1'b1;
        level_now      = '0;
        level_goal     = '0;
        ramp_on        = 1'b0;
        seq_mode       = MODE_DISARMED;
        act_stat       = (op == OP_STOP_ERR) ? STAT_ERROR : STAT_STOPPED;
      end
      OP_ARM: begin
        if (ready && seq_mode == MODE_DISARMED) begin
          res.ok         = 1'b1;
          res.drive_stop = 1'b1;
          ms_count       = '0;
          arm_hold       = arm_ms;
          seq_mode       = MODE_ARMING;
        end
      end
      OP_DISARM: begin
        if (ready && seq_mode == MODE_ARMED) begin
          res.ok         = 1'b1;
          res.drive_stop = 1'b1;
          level_now      = '0;
          level_goal     = '0;
          ramp_on        = 1'b0;
          seq_mode       = MODE_DISARMED;
        end
      end
      OP_SET: begin
        if (ready && (seq_mode == MODE_ARMED || seq_mode == MODE_RUNNING)) begin
          if (smooth) begin
            level_from = level_now;
            level_goal = req;
            ramp_span  = ramp_ms;
            ms_count   = '0;
            ramp_on    = 1'b1;
            if (req != '0) seq_mode = MODE_RUNNING;
            act_stat   = STAT_ACTIVE;
          end else begin
            // an immediate set leaves a running ramp in place
            level_now       = req;
            level_goal      = req;
            res.drive_write = 1'b1;
            seq_mode        = (req != '0) ? MODE_RUNNING : MODE_ARMED;
            act_stat        = (req != '0) ? STAT_ACTIVE : STAT_STOPPED;
          end
          res.ok      = 1'b1;
          res.applied = req;
        end
      end
      default: ;
    endcase
    gap = (level_now >= level_goal) ? level_now - level_goal : level_goal - level_now;
    res.throttle  = level_now;
    res.mode      = seq_mode;
    res.status    = act_stat;
    res.ramping   = ramp_on;
    res.at_target = (gap <= tol);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    esc_result_t want;
    if (!rst_ni) begin
      tol        = TOL_RESET;
      seq_mode   = MODE_DISARMED;
      act_stat   = STAT_INIT;
      level_now  = '0;
      level_goal = '0;
      level_from = '0;
      ramp_on    = 1'b0;
      ms_count   = '0;
      arm_hold   = '0;
      ramp_span  = '0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) tol = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t result with none expected: ok %0d throttle %0d mode %0d status %0d",
                   $time, ok_i, throttle_out_i, esc_mode_i, act_status_i);
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("ok", want.ok, ok_i);
          check_field("throttle_out", want.throttle, throttle_out_i);
          check_field("drive_write", want.drive_write, drive_write_i);
          check_field("drive_stop", want.drive_stop, drive_stop_i);
          check_field("esc_mode", want.mode, esc_mode_i);
          check_field("act_status", want.status, act_status_i);
          check_field("ramping", want.ramping, ramping_i);
          check_field("at_target", want.at_target, at_target_i);
          check_field("applied_throttle", want.applied, applied_throttle_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_sequencer(op_i, arm_time_ms_i, throttle_req_i, smooth_i, ramp_time_ms_i,
                          want);
        expected_results.push_back(want);
      end
    end
    pending_o    = expected_results.size();
    mismatches_o = mismatch_cnt;
  end

endmodule

// File: dv/esc_arming_throttle_ramp_tb.sv
module esc_arming_throttle_ramp_tb;
  import escatr_pkg::*;

  // op 7 has no name in the package; the block ignores it
  localparam logic [OP_W-1:0] OP_NOP = 3'd7;

  localparam int unsigned DRAIN_CYCLES = 24;   // margin past the worst-case latency
  localparam int unsigned LONG_HOLD    = 300;  // receiver hold-off that backs up the block
  localparam int unsigned PHASE_ITEMS  = 300;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [TOL_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [OP_W-1:0]      op_i;
  logic [TIME_IN_W-1:0] arm_time_ms_i;
  logic [LEVEL_W-1:0]   throttle_req_i;
  logic                 smooth_i;
  logic [TIME_IN_W-1:0] ramp_time_ms_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 ok_o;
  logic [LEVEL_W-1:0]   throttle_out_o;
  logic                 drive_write_o;
  logic                 drive_stop_o;
  logic [MODE_W-1:0]    esc_mode_o;
  logic [STAT_W-1:0]    act_status_o;
  logic                 ramping_o;
  logic                 at_target_o;
  logic [LEVEL_W-1:0]   applied_throttle_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned items_sent = 0;

  // Handshake between the stimulus process and the receiver process.
  bit quiet     = 1'b0;  // final phase: no idling on either side
  bit want_hold = 1'b0;  // ask the receiver for one long hold-off
  bit hold_done = 1'b0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  esc_arming_throttle_ramp dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .arm_time_ms_i     (arm_time_ms_i),
    .throttle_req_i    (throttle_req_i),
    .smooth_i          (smooth_i),
    .ramp_time_ms_i    (ramp_time_ms_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .ok_o              (ok_o),
    .throttle_out_o    (throttle_out_o),
    .drive_write_o     (drive_write_o),
    .drive_stop_o      (drive_stop_o),
    .esc_mode_o        (esc_mode_o),
    .act_status_o      (act_status_o),
    .ramping_o         (ramping_o),
    .at_target_o       (at_target_o),
    .applied_throttle_o(applied_throttle_o)
  );

  esc_ramp_checker ramp_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .op_i              (op_i),
    .arm_time_ms_i     (arm_time_ms_i),
    .throttle_req_i    (throttle_req_i),
    .smooth_i          (smooth_i),
    .ramp_time_ms_i    (ramp_time_ms_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .ok_i              (ok_o),
    .throttle_out_i    (throttle_out_o),
    .drive_write_i     (drive_write_o),
    .drive_stop_i      (drive_stop_o),
    .esc_mode_i        (esc_mode_o),
    .act_status_i      (act_status_o),
    .ramping_i         (ramping_o),
    .at_target_i       (at_target_o),
    .applied_throttle_i(applied_throttle_o),
    .mismatches_o      (mismatches),
    .pending_o         (pending)
  );

  // Present one item and hold it until the transfer happens. Inputs change
  // on the falling edge; the stall is sampled on the rising edge.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [TIME_IN_W-1:0] arm,
                           input logic [LEVEL_W-1:0] req, input logic smth,
                           input logic [TIME_IN_W-1:0] ramp);
    // drop valid for a burst of random length now and then
    if (!quiet && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    op_i           <= op;
    arm_time_ms_i  <= arm;
    throttle_req_i <= req;
    smooth_i       <= smth;
    ramp_time_ms_i <= ramp;
    do @(posedge clk_i); while (in_stall_o);
    if (op != OP_NOP) items_sent++;
  endtask

  // Unused fields carry random bits so every input bit toggles.
  task automatic send_tick();
    send_item(OP_TICK, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_cmd(input logic [OP_W-1:0] op);
    send_item(op, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_noise();
    send_item(OP_W'($urandom), $urandom, $urandom, $urandom, $urandom);
  endtask

  // Throttle request: favor the ends of the range and the saturating region.
  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LEVEL_MAX;
      2:       return LEVEL_W'($urandom_range(10001, 16383));
      default: return LEVEL_W'($urandom_range(0, 10000));
    endcase
  endfunction

  // Ramp length: mostly short so ramps finish, sometimes zero or huge.
  function automatic logic [TIME_IN_W-1:0] pick_ramp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return TIME_IN_W'($urandom_range(29, 65535));
      default: return TIME_IN_W'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [TIME_IN_W-1:0] pick_hold();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return TIME_IN_W'($urandom_range(21, 65535));
      default: return TIME_IN_W'($urandom_range(1, 10));
    endcase
  endfunction

  // One flight: begin (mostly), arm, tick through a short hold, a few throttle
  // changes with ticks in between, then mostly some way back down.
  task automatic fly_once();
    int unsigned hold;
    int unsigned span;
    int unsigned n;
    hold = pick_hold();
    if ($urandom_range(0, 7) != 0) send_cmd(OP_BEGIN);
    send_item(OP_ARM, hold, $urandom, $urandom, $urandom);
    // a long hold keeps the block arming; give it a few ticks and move on
    n = (hold > 20) ? $urandom_range(1, 20) : hold + $urandom_range(0, 2);
    repeat (n) send_tick();
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          span = pick_ramp();
          send_item(OP_SET, $urandom, pick_level(), 1'b1, span);
          n = (span > 28) ? $urandom_range(0, 28) : $urandom_range(0, span + 2);
          repeat (n) send_tick();
        end
        7, 8: begin
          send_item(OP_SET, $urandom, pick_level(), 1'b0, $urandom);
          repeat ($urandom_range(0, 3)) send_tick();
        end
        default: send_noise();
      endcase
    end
    case ($urandom_range(0, 5))
      0: send_cmd(OP_STOP);
      1: send_cmd(OP_STOP_ERR);
      2: begin
        send_item(OP_SET, $urandom, '0, 1'b0, $urandom);
        send_cmd(OP_DISARM);
      end
      3: begin
        span = $urandom_range(0, 6);
        send_item(OP_SET, $urandom, '0, 1'b1, span);
        repeat (span + 1) send_tick();
        send_cmd(OP_DISARM);
      end
      default: ;  // leave the state as is for the next flight
    endcase
  endtask

  // Drop valid, wait for every expected result, then let the latency pass.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_tol(input logic [TOL_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Short directed pass: rejection before ready, the unused op, every
  // command but the plain stop, arming, saturation, an immediate set inside a
  // ramp, a zero ramp, the stop-to-armed completion and recovery from error.
  task automatic run_directed();
    send_tick();                                         // not ready yet
    send_item(OP_SET, $urandom, 14'd5000, 1'b0, $urandom);
    send_item(OP_ARM, 16'd3, $urandom, $urandom, $urandom);
    send_cmd(OP_NOP);
    send_item(OP_BEGIN, '1, '1, 1'b1, '1);               // fields ignored
    send_cmd(OP_DISARM);                                 // still disarmed
    send_tick();                                         // idle tick
    send_item(OP_SET, $urandom, 14'd4000, 1'b0, $urandom);
    send_item(OP_ARM, 16'd2, $urandom, $urandom, $urandom);
    send_item(OP_ARM, 16'd5, $urandom, $urandom, $urandom);
    send_item(OP_SET, $urandom, 14'd4000, 1'b0, $urandom);
    repeat (2) send_tick();                              // arming completes
    send_item(OP_SET, $urandom, '1, 1'b0, $urandom);      // saturates to full
    send_item(OP_SET, $urandom, '0, 1'b1, 16'd4);
    send_tick();
    send_item(OP_SET, $urandom, 14'd3333, 1'b0, $urandom); // ramp keeps going
    repeat (3) send_tick();
    send_item(OP_SET, $urandom, '0, 1'b1, '0);
    send_tick();                                         // zero-length ramp
    send_cmd(OP_DISARM);
    send_cmd(OP_STOP_ERR);
    send_tick();                                         // error: not ready
    send_cmd(OP_BEGIN);
  endtask

  // Receiver: stall bursts of random length between free runs, one
  // long hold-off on request, and no stalls at all in the final phase.
  initial begin
    int unsigned stall_left;
    int unsigned run_left;
    out_stall_i = 1'b0;
    stall_left  = 0;
    run_left    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_stall_i <= 1'b0;
      end else if (want_hold && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (run_left != 0) begin
        out_stall_i <= 1'b0;
        run_left--;
      end else if ($urandom_range(0, 1) != 0) begin
        stall_left   = $urandom_range(0, 15);
        out_stall_i <= 1'b1;
      end else begin
        run_left     = $urandom_range(0, 39);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [TOL_W-1:0] tol_plan[6];
    int unsigned      phase_end;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    op_i           = OP_TICK;
    arm_time_ms_i  = '0;
    throttle_req_i = '0;
    smooth_i       = 1'b0;
    ramp_time_ms_i = '0;
    // tolerance settings: both ends, the top of the field, random, reset value
    tol_plan = '{14'd0, 14'h3FFF, 14'd10000, TOL_W'($urandom_range(0, 10000)), 14'd1,
                 TOL_RESET};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // run the directed part at the reset tolerance
    run_directed();

    foreach (tol_plan[p]) begin
      // change the tolerance only with the block drained
      settle();
      write_tol(tol_plan[p]);
      if (p == 1) want_hold = 1'b1;
      if (p == $size(tol_plan) - 1) quiet = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        fly_once();
        // sprinkle loose items between flights
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) send_noise();
      end
    end

    settle();
    if (mismatches == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
design/escatr_pkg.sv
design/escatr_dp.sv
design/escatr_ctrl.sv
design/esc_arming_throttle_ramp.sv
dv/esc_ramp_checker.sv
dv/esc_arming_throttle_ramp_tb.sv
